// ===== design/jtm_pkg.sv =====
// ============================================================================
// jtm_pkg : joystick thruster mapper shared types and constants
// field widths, event codes, register map and the divide-by-33000 reciprocal
// ============================================================================
package jtm_pkg;

    // field widths
    localparam int GAIN_W     = 8;
    localparam int CMD_W      = 16;
    localparam int LIFT_W     = 15;
    localparam int LEVEL_W    = 14;
    localparam int THRUST_W   = 8;
    localparam int TYPE_W     = 2;
    localparam int NUM_W      = 8;
    localparam int PROD_W     = GAIN_W + CMD_W;

    // config port
    localparam int APB_DATA_W = 32;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int ADDR_W     = REG_IDX_W + 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_ENABLE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FORWARD_GAIN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PITCH_GAIN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROLL_GAIN    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_YAW_GAIN     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIFT_GAIN    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RISE_LEVEL   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SINK_LEVEL   = 3'd7;

    // gain clamp and level reset values
    localparam logic signed [GAIN_W-1:0]  GAIN_MAX   = 8'sd100;
    localparam logic signed [GAIN_W-1:0]  GAIN_MIN   = -8'sd100;
    localparam logic [LEVEL_W-1:0]        RISE_RESET = 14'd10000;
    localparam logic signed [LEVEL_W-1:0] SINK_RESET = -14'sd5000;

    // event type codes
    localparam logic [TYPE_W-1:0] REQ_BUTTON = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_AXIS   = 2'd1;

    // button numbers
    localparam logic [NUM_W-1:0] BTN_RISE = 8'd1;
    localparam logic [NUM_W-1:0] BTN_SINK = 8'd2;
    localparam logic [NUM_W-1:0] BTN_ROLL = 8'd3;

    // axis assignment
    localparam logic [NUM_W-1:0] FORWARD_AXIS = 8'd2;
    localparam logic [NUM_W-1:0] PITCH_AXIS   = 8'd1;
    localparam logic [NUM_W-1:0] TURN_AXIS    = 8'd0;
    localparam logic             ROLL_INVERT  = 1'b0;

    // truncating divide by 33000 as multiply by rounded-up reciprocal
    // |gain*cmd| <= 100*32768 < 2**22, error term * 2**22 < 2**38
    localparam int      THRUST_DIV  = 33000;
    localparam int      ABS_W       = 22;
    localparam int      RECIP_SHIFT = 38;
    localparam int      RECIP_W     = 23;
    localparam int      QUOT_W      = 7;
    localparam longint  RECIP_VAL   = ((64'sd1 <<< RECIP_SHIFT) + THRUST_DIV - 1) / THRUST_DIV;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(RECIP_VAL);

    typedef struct packed {
        logic [TYPE_W-1:0]       req_type;
        logic [NUM_W-1:0]        event_number;
        logic signed [CMD_W-1:0] event_value;
    } t_in_item;

    typedef struct packed {
        logic signed [THRUST_W-1:0] forward_thrust;
        logic signed [THRUST_W-1:0] pitch_thrust;
        logic signed [THRUST_W-1:0] yaw_thrust;
        logic signed [THRUST_W-1:0] roll_thrust;
        logic signed [THRUST_W-1:0] lift_thrust;
        logic                       unmapped_button;
    } t_out_item;

    typedef struct packed {
        logic                       enable;
        logic signed [GAIN_W-1:0]   forward_gain;
        logic signed [GAIN_W-1:0]   pitch_gain;
        logic signed [GAIN_W-1:0]   roll_gain;
        logic signed [GAIN_W-1:0]   yaw_gain;
        logic signed [GAIN_W-1:0]   lift_gain;
        logic [LEVEL_W-1:0]         rise_level;
        logic signed [LEVEL_W-1:0]  sink_level;
    } t_cfg;

    // middle stage: raw gain*cmd products plus finished lift and flag
    typedef struct packed {
        logic signed [PROD_W-1:0]   forward_prod;
        logic signed [PROD_W-1:0]   pitch_prod;
        logic signed [PROD_W-1:0]   yaw_prod;
        logic signed [PROD_W-1:0]   roll_prod;
        logic signed [THRUST_W-1:0] lift_thrust;
        logic                       unmapped_button;
    } t_mid;

endpackage

// ===== design/jtm_cfg_regs.sv =====
// ============================================================================
// jtm_cfg_regs : configuration register file
// apb-style write and read of enable, gains and lift levels
// ============================================================================
module jtm_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jtm_pkg::ADDR_W-1:0]          paddr,
    input  logic [jtm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [jtm_pkg::APB_DATA_W-1:0]      prdata,
    output jtm_pkg::t_cfg                       o_cfg
);
    import jtm_pkg::*;

    logic                      r_enable;
    logic signed [GAIN_W-1:0]  r_forward_gain;
    logic signed [GAIN_W-1:0]  r_pitch_gain;
    logic signed [GAIN_W-1:0]  r_roll_gain;
    logic signed [GAIN_W-1:0]  r_yaw_gain;
    logic signed [GAIN_W-1:0]  r_lift_gain;
    logic [LEVEL_W-1:0]        r_rise_level;
    logic signed [LEVEL_W-1:0] r_sink_level;

    logic                      wr_en;
    logic [REG_IDX_W-1:0]      reg_idx;
    logic signed [GAIN_W-1:0]  wr_gain;

    // clamp to +-100
    function automatic logic signed [GAIN_W-1:0] sat_gain(
        input logic [GAIN_W-1:0] raw
    );
        logic signed [GAIN_W-1:0] g;
        g = $signed(raw);
        if (g > GAIN_MAX) begin
            sat_gain = GAIN_MAX;
        end else if (g < GAIN_MIN) begin
            sat_gain = GAIN_MIN;
        end else begin
            sat_gain = g;
        end
    endfunction

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_gain = sat_gain(pwdata[GAIN_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b1;
            r_forward_gain <= '0;
            r_pitch_gain   <= '0;
            r_roll_gain    <= '0;
            r_yaw_gain     <= '0;
            r_lift_gain    <= '0;
            r_rise_level   <= RISE_RESET;
            r_sink_level   <= SINK_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ENABLE:       r_enable       <= pwdata[0];
                REG_FORWARD_GAIN: r_forward_gain <= wr_gain;
                REG_PITCH_GAIN:   r_pitch_gain   <= wr_gain;
                REG_ROLL_GAIN:    r_roll_gain    <= wr_gain;
                REG_YAW_GAIN:     r_yaw_gain     <= wr_gain;
                REG_LIFT_GAIN:    r_lift_gain    <= wr_gain;
                REG_RISE_LEVEL:   r_rise_level   <= pwdata[LEVEL_W-1:0];
                REG_SINK_LEVEL:   r_sink_level   <= $signed(pwdata[LEVEL_W-1:0]);
                default:          r_enable       <= r_enable;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENABLE:       prdata = APB_DATA_W'(r_enable);
            REG_FORWARD_GAIN: prdata = APB_DATA_W'(r_forward_gain);
            REG_PITCH_GAIN:   prdata = APB_DATA_W'(r_pitch_gain);
            REG_ROLL_GAIN:    prdata = APB_DATA_W'(r_roll_gain);
            REG_YAW_GAIN:     prdata = APB_DATA_W'(r_yaw_gain);
            REG_LIFT_GAIN:    prdata = APB_DATA_W'(r_lift_gain);
            REG_RISE_LEVEL:   prdata = APB_DATA_W'(r_rise_level);
            REG_SINK_LEVEL:   prdata = APB_DATA_W'(r_sink_level);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.enable       = r_enable;
    assign o_cfg.forward_gain = r_forward_gain;
    assign o_cfg.pitch_gain   = r_pitch_gain;
    assign o_cfg.roll_gain    = r_roll_gain;
    assign o_cfg.yaw_gain     = r_yaw_gain;
    assign o_cfg.lift_gain    = r_lift_gain;
    assign o_cfg.rise_level   = r_rise_level;
    assign o_cfg.sink_level   = r_sink_level;

    // forward and lift gains always stay clamped
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_forward_gain <= GAIN_MAX && r_forward_gain >= GAIN_MIN &&
        r_lift_gain <= GAIN_MAX && r_lift_gain >= GAIN_MIN)
        else $error("gain register out of clamp range");

endmodule

// ===== design/jtm_cmd_update.sv =====
// ============================================================================
// jtm_cmd_update : latched axis commands and event decode
// applies one event to the command state and forms gain*cmd products
// ============================================================================
module jtm_cmd_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  jtm_pkg::t_in_item  i_item,
    input  jtm_pkg::t_cfg      i_cfg,
    output jtm_pkg::t_mid      o_mid
);
    import jtm_pkg::*;

    logic signed [CMD_W-1:0]  r_forward_cmd, n_forward_cmd;
    logic signed [CMD_W-1:0]  r_pitch_cmd,   n_pitch_cmd;
    logic signed [CMD_W-1:0]  r_roll_cmd,    n_roll_cmd;
    logic signed [CMD_W-1:0]  r_yaw_cmd,     n_yaw_cmd;
    logic signed [LIFT_W-1:0] r_lift_cmd,    n_lift_cmd;
    logic                     r_roll_mode,   n_roll_mode;

    logic                     down;
    logic                     unmapped;
    logic signed [LIFT_W-1:0] rise_ext;
    logic signed [LIFT_W-1:0] sink_ext;

    assign down     = (i_item.event_value == 16'sd1);
    assign rise_ext = $signed({1'b0, i_cfg.rise_level});
    assign sink_ext = LIFT_W'($signed(i_cfg.sink_level));

    always_comb begin
        n_forward_cmd = r_forward_cmd;
        n_pitch_cmd   = r_pitch_cmd;
        n_roll_cmd    = r_roll_cmd;
        n_yaw_cmd     = r_yaw_cmd;
        n_lift_cmd    = r_lift_cmd;
        n_roll_mode   = r_roll_mode;
        unmapped      = 1'b0;
        unique case (i_item.req_type)
            REQ_BUTTON: begin
                unique case (i_item.event_number)
                    BTN_RISE: n_lift_cmd  = down ? rise_ext : '0;
                    BTN_SINK: n_lift_cmd  = down ? sink_ext : '0;
                    BTN_ROLL: n_roll_mode = down;
                    default:  unmapped    = down;
                endcase
            end
            REQ_AXIS: begin
                // shared axis numbers: turn wins, then pitch, then forward
                priority if (i_item.event_number == TURN_AXIS) begin
                    if (r_roll_mode != ROLL_INVERT) begin
                        n_roll_cmd = i_item.event_value;
                        n_yaw_cmd  = '0;
                    end else begin
                        n_roll_cmd = '0;
                        n_yaw_cmd  = i_item.event_value;
                    end
                end else if (i_item.event_number == PITCH_AXIS) begin
                    n_pitch_cmd = i_item.event_value;
                end else if (i_item.event_number == FORWARD_AXIS) begin
                    n_forward_cmd = i_item.event_value;
                end else begin
                    n_forward_cmd = r_forward_cmd;
                end
            end
            default: unmapped = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward_cmd <= '0;
            r_pitch_cmd   <= '0;
            r_roll_cmd    <= '0;
            r_yaw_cmd     <= '0;
            r_lift_cmd    <= '0;
            r_roll_mode   <= 1'b0;
        end else if (i_step) begin
            r_forward_cmd <= n_forward_cmd;
            r_pitch_cmd   <= n_pitch_cmd;
            r_roll_cmd    <= n_roll_cmd;
            r_yaw_cmd     <= n_yaw_cmd;
            r_lift_cmd    <= n_lift_cmd;
            r_roll_mode   <= n_roll_mode;
        end
    end

    // products from the updated commands
    always_comb begin
        o_mid.forward_prod = PROD_W'($signed(i_cfg.forward_gain)) * PROD_W'(n_forward_cmd);
        o_mid.pitch_prod   = PROD_W'($signed(i_cfg.pitch_gain)) * PROD_W'(n_pitch_cmd);
        o_mid.yaw_prod     = PROD_W'($signed(i_cfg.yaw_gain)) * PROD_W'(n_yaw_cmd);
        o_mid.roll_prod    = PROD_W'($signed(i_cfg.roll_gain)) * PROD_W'(n_roll_cmd);
        // rise match takes precedence when both levels are equal
        if (n_lift_cmd == rise_ext) begin
            o_mid.lift_thrust = i_cfg.lift_gain;
        end else if (n_lift_cmd == sink_ext) begin
            o_mid.lift_thrust = -$signed(i_cfg.lift_gain);
        end else begin
            o_mid.lift_thrust = '0;
        end
        o_mid.unmapped_button = unmapped;
    end

    // turn axis only ever drives one of roll and yaw
    a_roll_yaw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_roll_cmd != '0) |-> (r_yaw_cmd == '0))
        else $error("roll and yaw commands both nonzero");

endmodule

// ===== design/jtm_thrust_div.sv =====
// ============================================================================
// jtm_thrust_div : one thrust channel divide
// signed product over 33000, truncated toward zero, by reciprocal multiply
// ============================================================================
module jtm_thrust_div (
    input  logic signed [jtm_pkg::PROD_W-1:0]   i_prod,
    output logic signed [jtm_pkg::THRUST_W-1:0] o_thrust
);
    import jtm_pkg::*;

    localparam int SCALED_W = ABS_W + RECIP_W;

    logic                  neg;
    logic [PROD_W-1:0]     mag_full;
    logic [ABS_W-1:0]      mag;
    logic [SCALED_W-1:0]   scaled;
    logic [QUOT_W-1:0]     quot;
    logic signed [THRUST_W-1:0] quot_s;

    always_comb begin
        neg      = i_prod[PROD_W-1];
        mag_full = neg ? PROD_W'(-i_prod) : PROD_W'(i_prod);
        mag      = mag_full[ABS_W-1:0];
        scaled   = SCALED_W'(mag) * SCALED_W'(RECIP_MUL);
        quot     = scaled[RECIP_SHIFT +: QUOT_W];
        quot_s   = $signed(THRUST_W'(quot));
        // restore sign: truncation toward zero
        o_thrust = neg ? -quot_s : quot_s;
    end

endmodule

// ===== design/joystick_thruster_mapper.sv =====
// ============================================================================
// joystick_thruster_mapper : joystick events to per-axis thrust values
// pipeline: an event passes the input register, then the command/product
//   stage, then the divide stage into the output register
// throughput: one event per cycle unless stalled; each stage advances on its
//   own, so a waiting result stalls only the stages that are full behind it
// reset: synchronous active low; clears commands, roll mode and pipeline
//   valids, loads register defaults (enable 1, gains 0, levels 10000/-5000)
// ============================================================================
module joystick_thruster_mapper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // event input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  jtm_pkg::t_in_item               i_in_data,
    // thrust result output
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output jtm_pkg::t_out_item              o_out_data,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jtm_pkg::ADDR_W-1:0]      paddr,
    input  logic [jtm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [jtm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import jtm_pkg::*;

    t_cfg       cfg;

    // stage 1: raw event register
    logic       r_in_valid;
    t_in_item   r_in;
    // stage 2: products and lift, commands already updated
    logic       r_mid_valid;
    t_mid       r_mid;
    t_mid       n_mid;
    // stage 3: result register
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;

    // per-stage free flags: a stage can load when empty or draining
    logic       out_free;
    logic       mid_free;
    logic       in_free;
    logic       step;

    assign out_free   = !r_out_valid || i_out_ready;
    assign mid_free   = !r_mid_valid || out_free;
    assign in_free    = !r_in_valid  || mid_free;
    assign o_in_ready = in_free;

    // event leaves stage 1: commands update only while enabled,
    // a disabled event is dropped here with no result
    assign step = r_in_valid && mid_free && cfg.enable;

    assign pready = 1'b1;

    jtm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    jtm_cmd_update u_cmd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_mid   (n_mid)
    );

    // four divide channels: forward, pitch, yaw and roll
    jtm_thrust_div u_div_fwd (.i_prod(r_mid.forward_prod), .o_thrust(n_out.forward_thrust));
    jtm_thrust_div u_div_pit (.i_prod(r_mid.pitch_prod),   .o_thrust(n_out.pitch_thrust));
    jtm_thrust_div u_div_yaw (.i_prod(r_mid.yaw_prod),     .o_thrust(n_out.yaw_thrust));
    jtm_thrust_div u_div_rol (.i_prod(r_mid.roll_prod),    .o_thrust(n_out.roll_thrust));

    assign n_out.lift_thrust     = r_mid.lift_thrust;
    assign n_out.unmapped_button = r_mid.unmapped_button;

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_in_valid;
            end
            if (mid_free) begin
                r_mid_valid <= r_in_valid && cfg.enable;
            end
            if (out_free) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    // pipeline payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_free) begin
            r_in <= i_in_data;
        end
        if (mid_free) begin
            r_mid <= n_mid;
        end
        if (out_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a disabled event never reaches the product stage
    a_disabled_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mid_free && !cfg.enable) |=> !r_mid_valid)
        else $error("disabled event produced a pending result");

    // a result only appears when the product stage held an event
    a_out_from_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_mid_valid))
        else $error("result appeared without a product stage event");

    // a blocked event waits in stage 1 untouched
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !mid_free) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled event lost or changed in input register");

endmodule
